@@ hdl/slrg_pkg.sv @@
// Shared types, constants and arithmetic helpers for the shuffled Lehmer generator.
// No dependencies; the front end, back end and top refer to it by scoped names.
package slrg_pkg;

    localparam logic [30:0] LEHMER_MOD   = 31'h7FFF_FFFF;
    localparam logic [14:0] LEHMER_MUL   = 15'd16807;
    localparam logic [23:0] FRACTION_MAX = 24'd16777213;

    typedef enum logic
    {
        CMD_DRAW,
        CMD_RESTART
    } slrg_kind_t;

    typedef struct packed
    {
        logic       valid;
        slrg_kind_t kind;
    } slrg_cmd_t;

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_WARM,
        ST_INDEX,
        ST_FINISH
    } slrg_state_t;

    // One generator step: x * 16807 mod (2^31 - 1), folded as a Mersenne residue.
    function automatic logic [30:0] lehmer_next(input logic [30:0] x);
        logic [45:0] prod;
        logic [31:0] fold;
        prod = {15'd0, x} * {31'd0, LEHMER_MUL};
        fold = {1'b0, prod[30:0]} + {17'd0, prod[45:31]};
        if (fold >= {1'b0, LEHMER_MOD})
        begin
            fold = fold - {1'b0, LEHMER_MOD};
        end
        return fold[30:0];
    endfunction

    // floor(v * 2^24 / (2^31 - 1)), clamped; the quotient is v >> 7 or one more.
    function automatic logic [23:0] fraction_of(input logic [30:0] v);
        logic [24:0] q_lo;
        logic [24:0] q_hi;
        logic [55:0] prod_hi;
        logic [55:0] scaled;
        logic [24:0] q;
        q_lo    = {1'b0, v[30:7]};
        q_hi    = q_lo + 25'd1;
        prod_hi = {q_hi, 31'd0} - {31'd0, q_hi};
        scaled  = {1'b0, v, 24'd0};
        q       = (prod_hi <= scaled) ? q_hi : q_lo;
        return (q > {1'b0, FRACTION_MAX}) ? FRACTION_MAX : q[23:0];
    endfunction

endpackage

@@ hdl/slrg_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module slrg_ram #(
    parameter int WIDTH = 31,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule

@@ hdl/slrg_front.sv @@
// Request front end: accept request beats, classify them, queue them for the back end.
// Depends on slrg_pkg.
module slrg_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  logic               req_restart,
    output slrg_pkg::slrg_cmd_t cmd,
    input  logic               cmd_pop
);

    logic                 wr_ptr_reg;
    logic                 rd_ptr_reg;
    logic [1:0]           count_reg;
    slrg_pkg::slrg_kind_t kind_reg [2];
    slrg_pkg::slrg_kind_t kind_in;
    logic                 push;
    logic                 pop;

    assign kind_in   = req_restart ? slrg_pkg::CMD_RESTART : slrg_pkg::CMD_DRAW;
    assign req_ready = (count_reg != 2'd2);
    assign push      = req_valid && req_ready;
    assign pop       = cmd_pop && (count_reg != 2'd0);

    assign cmd.valid = (count_reg != 2'd0);
    assign cmd.kind  = kind_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            kind_reg[wr_ptr_reg] <= kind_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

@@ hdl/slrg_back.sv @@
// Draw engine: warm-up sequencer, Lehmer step, shuffle index, table access, result register.
// Depends on slrg_pkg and slrg_ram.
module slrg_back #(
    parameter int TABLE_SIZE     = 32,
    parameter int WARMUP_DISCARD = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [30:0]         seed,
    input  slrg_pkg::slrg_cmd_t cmd,
    output logic                cmd_pop,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [30:0]         out_sample,
    output logic [23:0]         out_fraction
);

    localparam int IDX_W = $clog2(TABLE_SIZE);
    localparam int STEPS = WARMUP_DISCARD + TABLE_SIZE;
    localparam int CNT_W = $clog2(STEPS);
    localparam logic [CNT_W-1:0] CNT_LAST    = CNT_W'(STEPS - 1);
    localparam logic [CNT_W-1:0] CNT_DISCARD = CNT_W'(WARMUP_DISCARD);
    localparam logic [37:0] TSZ = 38'(TABLE_SIZE);
    localparam logic [37:0] DIV = 38'(64'd2147483646 + 64'(TABLE_SIZE));

    slrg_pkg::slrg_state_t state_reg;
    slrg_pkg::slrg_state_t state_next;

    logic [30:0]      gen_reg;
    logic [30:0]      last_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [IDX_W-1:0] j_reg;
    logic             out_valid_reg;
    logic [30:0]      out_sample_reg;
    logic [23:0]      out_frac_reg;

    logic [30:0]      gen_step;
    logic             warm_needed;
    logic             out_free;
    logic [IDX_W-1:0] j_comb;
    logic [37:0]      scaled_last;
    logic [IDX_W-1:0] q_est;
    logic [37:0]      q_bound;

    logic             do_load;
    logic             do_warm;
    logic             do_index;
    logic             do_finish;
    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    logic [30:0]      ram_wdata;
    logic [30:0]      ram_rdata;
    logic [CNT_W-1:0] fill_pos;

    assign gen_step    = slrg_pkg::lehmer_next(gen_reg);
    assign warm_needed = (cmd.kind == slrg_pkg::CMD_RESTART) || (last_reg == 31'd0);
    assign out_free    = !out_valid_reg || out_ready;

    // Index estimate from the power-of-two divisor, then correct down by one.
    assign scaled_last = {7'd0, last_reg} * TSZ;
    assign q_est       = scaled_last[31 +: IDX_W];
    assign q_bound     = {{(38 - IDX_W){1'b0}}, q_est} * DIV;
    assign j_comb      = (scaled_last >= q_bound) ? q_est : (q_est - IDX_W'(1));

    assign fill_pos = CNT_LAST - cnt_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            slrg_pkg::ST_IDLE:
            begin
                if (cmd.valid)
                begin
                    state_next = warm_needed ? slrg_pkg::ST_WARM : slrg_pkg::ST_FINISH;
                end
            end
            slrg_pkg::ST_WARM:
            begin
                if (cnt_reg == CNT_LAST)
                begin
                    state_next = slrg_pkg::ST_INDEX;
                end
            end
            slrg_pkg::ST_INDEX:
            begin
                state_next = slrg_pkg::ST_FINISH;
            end
            slrg_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = slrg_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = slrg_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd_pop   = 1'b0;
        do_load   = 1'b0;
        do_warm   = 1'b0;
        do_index  = 1'b0;
        do_finish = 1'b0;
        case (state_reg)
            slrg_pkg::ST_IDLE:
            begin
                cmd_pop  = cmd.valid;
                do_load  = cmd.valid && warm_needed;
                do_index = cmd.valid && !warm_needed;
            end
            slrg_pkg::ST_WARM:
            begin
                do_warm = 1'b1;
            end
            slrg_pkg::ST_INDEX:
            begin
                do_index = 1'b1;
            end
            slrg_pkg::ST_FINISH:
            begin
                do_finish = out_free;
            end
            default:
            begin
                cmd_pop = 1'b0;
            end
        endcase
    end

    // Fill the table top down during warm-up; write the fresh value back on a draw.
    assign ram_we    = (do_warm && (cnt_reg >= CNT_DISCARD)) || do_finish;
    assign ram_waddr = do_warm ? fill_pos[IDX_W-1:0] : j_reg;
    assign ram_wdata = do_warm ? gen_step : gen_reg;

    slrg_ram #(
        .WIDTH (31),
        .DEPTH (TABLE_SIZE)
    ) u_table (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (do_index),
        .rd_addr (j_comb),
        .rd_data (ram_rdata)
    );

    always_ff @(posedge clk)
    begin
        if (do_index)
        begin
            j_reg <= j_comb;
        end
        if (do_finish)
        begin
            out_sample_reg <= ram_rdata;
            out_frac_reg   <= slrg_pkg::fraction_of(ram_rdata);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= slrg_pkg::ST_IDLE;
            gen_reg       <= 31'd0;
            last_reg      <= 31'd0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (do_load)
            begin
                gen_reg <= seed;
                cnt_reg <= '0;
            end
            if (do_warm)
            begin
                gen_reg <= gen_step;
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_LAST)
                begin
                    last_reg <= gen_step;
                end
            end
            if (do_index)
            begin
                gen_reg <= gen_step;
            end
            if (do_finish)
            begin
                last_reg      <= ram_rdata;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_sample   = out_sample_reg;
    assign out_fraction = out_frac_reg;

endmodule

@@ hdl/shuffled_lehmer_random_generator.sv @@
// Shuffled Lehmer generator: Park-Miller step behind a shuffle table in RAM.
// A normal draw's request beat is queued; the engine then reads its table entry in the
// index step and registers the result beat in the finish step, which also writes the
// fresh value back to the table; the next request starts only after that write-back.
// A warm-up (first request, restart, or zero output) reloads the seed, then runs one
// Lehmer step per cycle through the single modular multiply unit to refill the table.
// Reset: seed returns to 1, generator and last output clear, the queue empties.
// Depends on slrg_pkg, slrg_front, slrg_back and slrg_ram.
module shuffled_lehmer_random_generator #(
    parameter int TABLE_SIZE     = 32,
    parameter int WARMUP_DISCARD = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    // seed register write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [30:0] cfg_data,     // [30:0] seed_value
    // request beats
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,      // [0] restart, [7:1] zero fill
    // result beats
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata       // [30:0] sample, [54:31] fraction, [55] zero fill
);

    logic [30:0]         seed_reg;
    slrg_pkg::slrg_cmd_t cmd;
    logic                cmd_pop;
    logic [30:0]         sample;
    logic [23:0]         fraction;

    // The seed register always takes a write; it only matters at the next warm-up.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= 31'd1;
        end
        else if (cfg_valid)
        begin
            seed_reg <= cfg_data;
        end
    end

    // Front end: take request beats into a two-deep command queue.
    slrg_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (s_tvalid),
        .req_ready   (s_tready),
        .req_restart (s_tdata[0]),
        .cmd         (cmd),
        .cmd_pop     (cmd_pop)
    );

    // Back end: warm up when needed, advance, shuffle, and hold the result beat.
    slrg_back #(
        .TABLE_SIZE     (TABLE_SIZE),
        .WARMUP_DISCARD (WARMUP_DISCARD)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .seed         (seed_reg),
        .cmd          (cmd),
        .cmd_pop      (cmd_pop),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_sample   (sample),
        .out_fraction (fraction)
    );

    assign m_tdata = {1'b0, fraction, sample};

endmodule
